FILE: sv/satlb_pkg.sv
// satlb_pkg: shared sizes, opcodes and types of the set-associative TLB.
// No dependencies; every other file of the block but satlb_ram imports it.
package satlb_pkg;

    localparam int SETS    = 16;
    localparam int WAYS    = 4;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W   = $clog2(SETS + 1);
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 4;
    localparam int TAG_W   = 20;
    localparam int FRAME_W = 20;
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = TAG_W + FRAME_W + STAMP_W;
    localparam int ROW_W   = ENTRY_W * WAYS;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    // Way selection results for one set row
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim_way;
    } sel_t;

endpackage

FILE: sv/satlb_req_if.sv
// satlb_req_if: request channel (valid/ready plus request fields).
// Depends on satlb_pkg.
interface satlb_req_if import satlb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     set_index;
    logic [TAG_W-1:0]     tag;
    logic [FRAME_W-1:0]   frame;
    logic [STAMP_W-1:0]   access_time;

    modport source (output valid, mode, set_index, tag, frame, access_time, input ready);
    modport sink   (input valid, mode, set_index, tag, frame, access_time, output ready);
endinterface

FILE: sv/satlb_rsp_if.sv
// satlb_rsp_if: response channel (valid/ready plus hit and frame).
// Depends on satlb_pkg.
interface satlb_rsp_if import satlb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] frame_out;

    modport source (output valid, hit, frame_out, input ready);
    modport sink   (input valid, hit, frame_out, output ready);
endinterface

FILE: sv/satlb_ram.sv
// satlb_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module satlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/satlb_way_sel.sv
// satlb_way_sel: hit detection and LRU victim choice over one set row.
// Depends on satlb_pkg.
module satlb_way_sel import satlb_pkg::*; (
    input  row_t             row,
    input  logic [WAYS-1:0]  vld,
    input  logic [TAG_W-1:0] tag,
    output sel_t             sel
);

    localparam int N2 = 1 << WAY_W;

    logic [STAMP_W-1:0] t_stamp [WAY_W+1][N2];
    logic [WAY_W-1:0]   t_idx   [WAY_W+1][N2];
    logic               t_use   [WAY_W+1][N2];
    logic               free_found;
    logic [WAY_W-1:0]   free_way;
    logic               hit_found;
    logic [WAY_W-1:0]   hit_idx;

    // Lowest valid matching way, lowest invalid way
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vld[w] && (row[w].tag == tag))
            begin
                hit_found = 1'b1;
                hit_idx   = WAY_W'(w);
            end
            if (!vld[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    // Minimum-stamp tree; ties keep the lower way
    always_comb
    begin
        for (int l = 0; l <= WAY_W; l++)
        begin
            for (int i = 0; i < N2; i++)
            begin
                t_stamp[l][i] = '0;
                t_idx[l][i]   = '0;
                t_use[l][i]   = 1'b0;
            end
        end
        for (int i = 0; i < N2; i++)
        begin
            t_use[0][i]   = (i < WAYS);
            t_stamp[0][i] = row[(i < WAYS) ? i : 0].stamp;
            t_idx[0][i]   = WAY_W'(i);
        end
        for (int l = 1; l <= WAY_W; l++)
        begin
            for (int i = 0; i < (N2 >> l); i++)
            begin
                if (t_use[l-1][2*i+1] &&
                    (!t_use[l-1][2*i] || (t_stamp[l-1][2*i+1] < t_stamp[l-1][2*i])))
                begin
                    t_stamp[l][i] = t_stamp[l-1][2*i+1];
                    t_idx[l][i]   = t_idx[l-1][2*i+1];
                    t_use[l][i]   = 1'b1;
                end
                else
                begin
                    t_stamp[l][i] = t_stamp[l-1][2*i];
                    t_idx[l][i]   = t_idx[l-1][2*i];
                    t_use[l][i]   = t_use[l-1][2*i];
                end
            end
        end
        sel.hit        = hit_found;
        sel.hit_way    = hit_idx;
        sel.victim_way = free_found ? free_way : t_idx[WAY_W][0];
    end

endmodule

FILE: sv/set_assoc_tlb_lru.sv
// set_assoc_tlb_lru: set-associative TLB with timestamp LRU replacement.
// Depends on satlb_pkg, satlb_req_if, satlb_rsp_if, satlb_ram, satlb_way_sel.
//
// Usage
//   req (sink): one request per valid/ready handshake. mode selects lookup,
//   insert, or invalidate-by-frame; set_index, tag, frame and access_time
//   are its operands. rsp (source): exactly one response per request, in
//   request order; hit/frame_out carry the lookup result, zero otherwise.
//   Lookup, insert and the unused mode read the set row from the row RAM,
//   then select the way and, on a lookup hit or an insert, write the row
//   back while completing; a new request is taken only once the previous
//   one has completed. An invalidate reads every set row once through the
//   same RAM port before it completes.
//   A response waits in the output register; the next request is still
//   taken and processed, and only its completion holds until the output
//   register frees up, so a stalled receiver backs up one request deep.
//   Reset clears all valid bits and control state at once; tag, frame and
//   stamp contents are never read before a write, so no clearing pass is
//   needed and requests are taken in the first cycle after reset.
module set_assoc_tlb_lru import satlb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    satlb_req_if.sink   req,
    satlb_rsp_if.source rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [MODE_W-1:0]        op_mode_reg, op_mode_next;
    logic [TAG_W-1:0]         op_tag_reg, op_tag_next;
    logic [FRAME_W-1:0]       op_frame_reg, op_frame_next;
    logic [STAMP_W-1:0]       op_time_reg, op_time_next;
    logic                     set_ok_reg, set_ok_next;
    logic [SET_W-1:0]         cur_set_reg, cur_set_next;
    logic [CNT_W-1:0]         sweep_cnt_reg, sweep_cnt_next;
    logic                     chk_vld_reg, chk_vld_next;
    logic [SETS-1:0][WAYS-1:0] valid_reg, valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_hit_reg, out_hit_next;
    logic [FRAME_W-1:0]       out_frame_reg, out_frame_next;

    logic                     ram_we, ram_re;
    logic [SET_W-1:0]         ram_raddr;
    logic [ROW_W-1:0]         ram_rdata;
    row_t                     rd_row, wr_row;
    logic [WAYS-1:0]          set_vld;
    sel_t                     sel;
    logic                     out_free;
    logic                     accept;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign rd_row   = row_t'(ram_rdata);
    assign set_vld  = valid_reg[cur_set_reg];

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.frame_out = out_frame_reg;

    satlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_set_reg),
        .wdata (wr_row),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    satlb_way_sel u_way_sel (
        .row (rd_row),
        .vld (set_vld),
        .tag (op_tag_reg),
        .sel (sel)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_mode_next   = op_mode_reg;
        op_tag_next    = op_tag_reg;
        op_frame_next  = op_frame_reg;
        op_time_next   = op_time_reg;
        set_ok_next    = set_ok_reg;
        cur_set_next   = cur_set_reg;
        sweep_cnt_next = sweep_cnt_reg;
        chk_vld_next   = 1'b0;
        valid_next     = valid_reg;
        out_hit_next   = out_hit_reg;
        out_frame_next = out_frame_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = SET_W'(req.set_index);
        wr_row         = rd_row;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Capture the request; start the set row read unless it is an invalidate
                    op_mode_next   = req.mode;
                    op_tag_next    = req.tag;
                    op_frame_next  = req.frame;
                    op_time_next   = req.access_time;
                    set_ok_next    = (32'(req.set_index) < SETS);
                    cur_set_next   = SET_W'(req.set_index);
                    sweep_cnt_next = '0;
                    if (req.mode == MODE_INVAL)
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end

            S_SWEEP:
            begin
                // Check the row read last cycle, drop matching valid entries
                if (chk_vld_reg)
                begin
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (set_vld[w] && (rd_row[w].frame == op_frame_reg))
                        begin
                            valid_next[cur_set_reg][w] = 1'b0;
                        end
                    end
                end
                if (sweep_cnt_reg != CNT_W'(SETS))
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = sweep_cnt_reg[SET_W-1:0];
                    cur_set_next   = sweep_cnt_reg[SET_W-1:0];
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                    chk_vld_next   = 1'b1;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Hold until the output register can take the response
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b0;
                    out_frame_next = '0;
                    state_next     = S_IDLE;
                    if (set_ok_reg && (op_mode_reg == MODE_LOOKUP) && sel.hit)
                    begin
                        out_hit_next               = 1'b1;
                        out_frame_next             = rd_row[sel.hit_way].frame;
                        wr_row[sel.hit_way].stamp  = op_time_reg;
                        ram_we                     = 1'b1;
                    end
                    else if (set_ok_reg && (op_mode_reg == MODE_INSERT))
                    begin
                        wr_row[sel.victim_way].tag    = op_tag_reg;
                        wr_row[sel.victim_way].frame  = op_frame_reg;
                        wr_row[sel.victim_way].stamp  = op_time_reg;
                        valid_next[cur_set_reg][sel.victim_way] = 1'b1;
                        ram_we                        = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sweep_cnt_reg <= '0;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg   <= op_mode_next;
        op_tag_reg    <= op_tag_next;
        op_frame_reg  <= op_frame_next;
        op_time_reg   <= op_time_next;
        set_ok_reg    <= set_ok_next;
        cur_set_reg   <= cur_set_next;
        out_hit_reg   <= out_hit_next;
        out_frame_reg <= out_frame_next;
    end

    // Row write-back only happens while completing a request
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EXEC))
        else $error("row write outside completion");

    // An accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    // A new response appears only after a completion cycle
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC))
        else $error("response without completion");

    // Sweep row checks only occur inside a sweep
    a_chk_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_SWEEP))
        else $error("sweep check outside sweep");

endmodule

FILE: verif/set_assoc_tlb_lru_tb.sv
`timescale 1ns / 100ps
// set_assoc_tlb_lru_tb: self-checking bench for the set-associative TLB with timestamp LRU.
// Depends on satlb_pkg, satlb_req_if, satlb_rsp_if and the set_assoc_tlb_lru top level.
module set_assoc_tlb_lru_tb;
    import satlb_pkg::*;

    // Mode code the block treats as a no-op
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Cycles with no handshake on either channel before the run is declared hung.
    // Slowest legal gap is an invalidate sweep plus a long receiver stall.
    localparam int STALL_LIMIT = 2000;

    // Cycles to wait after the last response, covering one full invalidate sweep
    localparam int DRAIN_CYCLES = SETS + 8;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   set_index;
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
        logic [STAMP_W-1:0] access_time;
    } tlb_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
    } tlb_rsp_t;

    logic clk;
    logic rst_n;

    satlb_req_if req_ch ();
    satlb_rsp_if rsp_ch ();

    set_assoc_tlb_lru dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the TLB contents, indexed by set * WAYS + way
    logic               shadow_valid [SETS*WAYS];
    logic [TAG_W-1:0]   shadow_tag   [SETS*WAYS];
    logic [FRAME_W-1:0] shadow_frame [SETS*WAYS];
    logic [STAMP_W-1:0] shadow_stamp [SETS*WAYS];

    // Responses owed by the block, oldest first
    tlb_rsp_t owed_rsp [$];

    int err_count;
    int src_idle_pct;
    int stall_pct;
    int quiet_cycles;
    logic [STAMP_W-1:0] stamp_clock;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Compute the response to one request and advance the shadow state
    function automatic tlb_rsp_t predict_tlb(tlb_req_t r);
        tlb_rsp_t res;
        int base;
        int pick;
        logic [STAMP_W-1:0] oldest;
        logic done;
        res = '0;
        base = int'(r.set_index) * WAYS;
        done = 1'b0;
        case (r.mode)
            MODE_LOOKUP:
            begin
                if (int'(r.set_index) < SETS)
                begin
                    // First valid way with a matching tag wins; restamp it
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (!done && shadow_valid[base+w] && shadow_tag[base+w] == r.tag)
                        begin
                            shadow_stamp[base+w] = r.access_time;
                            res.hit = 1'b1;
                            res.frame_out = shadow_frame[base+w];
                            done = 1'b1;
                        end
                    end
                end
            end
            MODE_INSERT:
            begin
                if (int'(r.set_index) < SETS)
                begin
                    // First free way, else smallest stamp with the lowest way on ties
                    pick = 0;
                    oldest = '0;
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (!done)
                        begin
                            if (!shadow_valid[base+w])
                            begin
                                pick = w;
                                done = 1'b1;
                            end
                            else if (w == 0 || shadow_stamp[base+w] < oldest)
                            begin
                                oldest = shadow_stamp[base+w];
                                pick = w;
                            end
                        end
                    end
                    shadow_valid[base+pick] = 1'b1;
                    shadow_tag[base+pick]   = r.tag;
                    shadow_frame[base+pick] = r.frame;
                    shadow_stamp[base+pick] = r.access_time;
                end
            end
            MODE_INVAL:
            begin
                // Sweep all sets; only the valid bit drops
                for (int e = 0; e < SETS*WAYS; e++)
                begin
                    if (shadow_valid[e] && shadow_frame[e] == r.frame)
                        shadow_valid[e] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Send one request: optional idle gap, then hold valid until the handshake.
    // Valid stays high on return so back-to-back requests need no extra edge.
    task automatic send_req(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] s,
                            input logic [TAG_W-1:0] t, input logic [FRAME_W-1:0] f,
                            input logic [STAMP_W-1:0] a);
        tlb_req_t r;
        int gap;
        r = '{mode: m, set_index: s, tag: t, frame: f, access_time: a};
        gap = 0;
        while (gap < 16 && $urandom_range(99) < src_idle_pct)
            gap++;
        repeat (gap) @(negedge clk) req_ch.valid <= 1'b0;
        @(negedge clk);
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= r.mode;
        req_ch.set_index   <= r.set_index;
        req_ch.tag         <= r.tag;
        req_ch.frame       <= r.frame;
        req_ch.access_time <= r.access_time;
        do
            @(posedge clk);
        while (!req_ch.ready);
        owed_rsp.push_back(predict_tlb(r));
    endtask

    // Empty TLB, then field extremes in the first and last set, plus a duplicate tag
    task automatic test_lookup_insert_extremes();
        send_req(MODE_LOOKUP, 4'd0, 20'h00000, 20'h00000, 32'h0000_0000);
        send_req(MODE_INSERT, 4'd0, 20'h00000, 20'h00000, 32'h0000_0000);
        send_req(MODE_INSERT, 4'd15, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
        send_req(MODE_LOOKUP, 4'd0, 20'h00000, 20'hFFFFF, 32'h0000_0005);
        send_req(MODE_LOOKUP, 4'd15, 20'hFFFFF, 20'h00000, 32'hFFFF_FFFF);
        send_req(MODE_LOOKUP, 4'd0, 20'hFFFFF, 20'h00000, 32'h0000_0006);
        // Duplicate tag lands in a second way; lookup must still return the first
        send_req(MODE_INSERT, 4'd0, 20'h00000, 20'h12345, 32'h0000_0007);
        send_req(MODE_LOOKUP, 4'd0, 20'h00000, 20'h00000, 32'h0000_0008);
        send_req(MODE_LOOKUP, 4'd15, 20'h00000, 20'h00000, 32'h0000_0009);
    endtask

    // Fill one set, then evict: equal stamps, unsigned compare, restamp on hit
    task automatic test_lru_replacement();
        send_req(MODE_INSERT, 4'd7, 20'hA0A0A, 20'h0000A, 32'h8000_0000);
        send_req(MODE_INSERT, 4'd7, 20'hB0B0B, 20'h0000B, 32'h7FFF_FFFF);
        send_req(MODE_INSERT, 4'd7, 20'hC0C0C, 20'h0000C, 32'h7FFF_FFFF);
        send_req(MODE_INSERT, 4'd7, 20'hD0D0D, 20'h0000D, 32'h9000_0000);
        // Ways 1 and 2 tie on the smallest stamp; way 1 goes
        send_req(MODE_INSERT, 4'd7, 20'hE0E0E, 20'h0000E, 32'hA000_0000);
        send_req(MODE_LOOKUP, 4'd7, 20'hB0B0B, 20'h00000, 32'hA000_0001);
        // Hit on way 2 lifts its stamp above everything else
        send_req(MODE_LOOKUP, 4'd7, 20'hC0C0C, 20'h00000, 32'hFFFF_FFF0);
        send_req(MODE_INSERT, 4'd7, 20'hF0F0F, 20'h0000F, 32'hA000_0002);
        send_req(MODE_LOOKUP, 4'd7, 20'hA0A0A, 20'h00000, 32'hA000_0003);
    endtask

    // Same frame in two sets; one sweep clears both and frees their ways
    task automatic test_invalidate_sweep();
        send_req(MODE_INSERT, 4'd2, 20'h00001, 20'h55555, 32'h0000_0100);
        send_req(MODE_INSERT, 4'd9, 20'h00002, 20'h55555, 32'h0000_0101);
        send_req(MODE_INVAL, 4'd0, 20'h00000, 20'h55555, 32'h0000_0102);
        send_req(MODE_LOOKUP, 4'd2, 20'h00001, 20'h00000, 32'h0000_0103);
        send_req(MODE_LOOKUP, 4'd9, 20'h00002, 20'h00000, 32'h0000_0104);
        send_req(MODE_INSERT, 4'd2, 20'h00003, 20'h00006, 32'h0000_0105);
        send_req(MODE_LOOKUP, 4'd2, 20'h00003, 20'h00000, 32'h0000_0106);
    endtask

    // The spare mode code must leave the contents untouched
    task automatic test_unused_mode();
        send_req(MODE_UNUSED, 4'd0, 20'h00000, 20'h00000, 32'h0000_0000);
        send_req(MODE_LOOKUP, 4'd0, 20'h00000, 20'h00000, 32'h0000_0200);
    endtask

    // Mostly pooled tags and frames, pooled sets half the time, so hits, evictions and
    // sweeps really happen; the rest is full-range noise so every field bit toggles.
    task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
        logic [TAG_W-1:0]   tag_pool   [8];
        logic [FRAME_W-1:0] frame_pool [8];
        logic [IDX_W-1:0]   set_pool   [4];
        logic [MODE_W-1:0]  m;
        logic [IDX_W-1:0]   s;
        logic [TAG_W-1:0]   t;
        logic [FRAME_W-1:0] f;
        logic [STAMP_W-1:0] a;
        int pick;
        src_idle_pct = src_pct;
        stall_pct    = snk_pct;
        foreach (tag_pool[i])
            tag_pool[i] = TAG_W'($urandom);
        foreach (frame_pool[i])
            frame_pool[i] = FRAME_W'($urandom);
        foreach (set_pool[i])
            set_pool[i] = IDX_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                m = MODE_LOOKUP;
            else if (pick < 80)
                m = MODE_INSERT;
            else if (pick < 92)
                m = MODE_INVAL;
            else
                m = MODE_UNUSED;
            s = ($urandom_range(1) == 1) ? set_pool[$urandom_range(3)] : IDX_W'($urandom);
            t = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(7)] : TAG_W'($urandom);
            f = ($urandom_range(99) < 85) ? frame_pool[$urandom_range(7)] : FRAME_W'($urandom);
            // Mostly a slowly rising clock with repeats; sometimes a wild stamp
            if ($urandom_range(99) < 15)
                a = $urandom;
            else
            begin
                stamp_clock = stamp_clock + STAMP_W'($urandom_range(3));
                a = stamp_clock;
            end
            send_req(m, s, t, f, a);
        end
    endtask

    // Receiver: drop ready at random according to the current stall rate
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Compare every accepted response with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_rsp.size() == 0)
            begin
                $error("unexpected response: hit %0d frame_out %05h",
                       rsp_ch.hit, rsp_ch.frame_out);
                err_count++;
            end
            else
            begin
                if (rsp_ch.hit !== owed_rsp[0].hit)
                begin
                    $error("hit: expected %0d, actual %0d", owed_rsp[0].hit, rsp_ch.hit);
                    err_count++;
                end
                if (rsp_ch.frame_out !== owed_rsp[0].frame_out)
                begin
                    $error("frame_out: expected %05h, actual %05h",
                           owed_rsp[0].frame_out, rsp_ch.frame_out);
                    err_count++;
                end
                void'(owed_rsp.pop_front());
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[set_assoc_tlb_lru] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // Known values on every input before reset releases
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_LOOKUP;
        req_ch.set_index   = '0;
        req_ch.tag         = '0;
        req_ch.frame       = '0;
        req_ch.access_time = '0;
        rsp_ch.ready       = 1'b0;
        err_count          = 0;
        src_idle_pct       = 0;
        stall_pct          = 0;
        quiet_cycles       = 0;
        stamp_clock        = 32'h0000_1000;
        foreach (shadow_valid[e])
        begin
            shadow_valid[e] = 1'b0;
            shadow_tag[e]   = '0;
            shadow_frame[e] = '0;
            shadow_stamp[e] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed checks run with no idling on either side
        test_lookup_insert_extremes();
        test_lru_replacement();
        test_invalidate_sweep();
        test_unused_mode();

        // Random traffic across the idling phases; state carries over between them
        test_random_traffic(190, 0, 0);
        test_random_traffic(190, 61, 0);
        test_random_traffic(190, 0, 61);
        test_random_traffic(190, 18, 18);

        @(negedge clk) req_ch.valid <= 1'b0;
        while (owed_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("[set_assoc_tlb_lru] OK");
        else
            $display("[set_assoc_tlb_lru] ERROR");
        $finish;
    end

endmodule
